FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/dsk_pkg.sv
package dsk_pkg;

  localparam int TrackSlotsDef = 8;
  localparam int MatrixRowsDef = 8;
  localparam int MatrixColsDef = 16;

  localparam int ActW     = 2;
  localparam int CodeW    = 16;
  localparam int RowW     = 3;
  localparam int ColW     = 4;
  localparam int DepthW   = 10;
  localparam int TimeW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int MaxOut  = 8;
  localparam int OutCntW = 4;

  localparam logic [DepthW-1:0] FullDepth = 10'd1000;

  // Division by 1000 is a multiplication by floor(2^32 / 1000) and one correction step.
  localparam int ProdW      = 26;
  localparam int RecipW     = 23;
  localparam int MulW       = ProdW + RecipW;
  localparam int RecipShift = 32;
  localparam int QuotW      = MulW - RecipShift;
  localparam logic [RecipW-1:0] RecipM   = 23'd4294967;
  localparam logic [RecipW-1:0] DivisorK = 23'd1000;

  typedef enum logic [ActW-1:0] {
    ActPress   = 2'd0,
    ActRelease = 2'd1,
    ActSample  = 2'd2,
    ActTick    = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRepeatEn = 3'd0,
    CfgMinIv    = 3'd1,
    CfgMaxIv    = 3'd2,
    CfgExclLo   = 3'd3,
    CfgExclHi   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MulScale = 2'd0,
    MulRecip = 2'd1,
    MulBack  = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic              en;
    mul_op_e           op;
    logic [ProdW-1:0]  a;
    logic [DepthW-1:0] depth;
  } mul_req_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StWalk,
    StMemRd,
    StMulP,
    StMulQ,
    StMulR,
    StCmp,
    StFlush
  } state_e;

endpackage

FILE: rtl/core/dsk_mul_unit.sv
module dsk_mul_unit (
  input  logic                      clk_i,
  input  dsk_pkg::mul_req_t         req_i,
  output logic [dsk_pkg::MulW-1:0]  prod_o
);
  import dsk_pkg::*;

  logic [RecipW-1:0] op_b;
  logic [MulW-1:0]   prod_q;

  always_comb begin
    case (req_i.op)
      MulScale: op_b = {{(RecipW-DepthW){1'b0}}, req_i.depth};
      MulRecip: op_b = RecipM;
      MulBack:  op_b = DivisorK;
      default:  op_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= {{RecipW{1'b0}}, req_i.a} * {{ProdW{1'b0}}, op_b};
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/core/dsk_cell_mem.sv
module dsk_cell_mem #(
  parameter int Cells = dsk_pkg::MatrixRowsDef * dsk_pkg::MatrixColsDef
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Cells > 1) ? $clog2(Cells) : 1)-1:0] waddr_i,
  input  logic [dsk_pkg::DepthW:0]              wdata_i,
  input  logic                                  re_i,
  input  logic [((Cells > 1) ? $clog2(Cells) : 1)-1:0] raddr_i,
  output logic [dsk_pkg::DepthW:0]              rdata_o
);
  import dsk_pkg::*;

  logic [DepthW:0] mem_q [Cells];
  logic [DepthW:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/depth_scaled_key_repeat_scheduler.sv
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   action, key, row, col, depth, held, time
// output    out        out_valid_o / out_stall_i keycode, row, col, reregister, last_in_run
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Samples and ignored items leave the block idle; a press or release walks the slots, one per cycle.
// A tick walks the slots in turn; an active slot inside the matrix adds a depth read and a compare,
// and three passes of the shared multiplier when its depth is below full and the minimum interval
// is below the maximum; the tick stalls the input until its walk and flush are done.
// After reset a clearing pass over all MATRIX_ROWS * MATRIX_COLS cells zeroes the depth store.
// One result waits in the output register while the next is prepared; a tick holds when both
// are full and the output is stalled.
module depth_scaled_key_repeat_scheduler #(
  parameter int TRACK_SLOTS = dsk_pkg::TrackSlotsDef,
  parameter int MATRIX_ROWS = dsk_pkg::MatrixRowsDef,
  parameter int MATRIX_COLS = dsk_pkg::MatrixColsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsk_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dsk_pkg::ActW-1:0]      action_i,
  input  logic [dsk_pkg::CodeW-1:0]     key_code_i,
  input  logic [dsk_pkg::RowW-1:0]      key_row_i,
  input  logic [dsk_pkg::ColW-1:0]      key_col_i,
  input  logic [dsk_pkg::DepthW-1:0]    depth_value_i,
  input  logic                          held_now_i,
  input  logic [dsk_pkg::TimeW-1:0]     now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dsk_pkg::CodeW-1:0]     out_keycode_o,
  output logic [dsk_pkg::RowW-1:0]      out_row_o,
  output logic [dsk_pkg::ColW-1:0]      out_col_o,
  output logic                          reregister_o,
  output logic                          last_in_run_o
);
  import dsk_pkg::*;

  localparam int Cells    = MATRIX_ROWS * MATRIX_COLS;
  localparam int CellW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int SlotW    = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int SlotCntW = $clog2(TRACK_SLOTS + 1);
  localparam logic [SlotCntW-1:0] SlotEnd  = SlotCntW'(TRACK_SLOTS);
  localparam logic [CellW-1:0]    CellLast = CellW'(Cells - 1);

  state_e state_q, state_d;
  logic [SlotCntW-1:0] idx_q, idx_d;
  logic [OutCntW-1:0]  nres_q, nres_d;
  logic [CellW-1:0]    clr_idx_q;

  logic              rep_en_q;
  logic [TimeW-1:0]  min_q, max_q;
  logic [CodeW-1:0]  excl_lo_q, excl_hi_q;

  logic [ActW-1:0]   act_q;
  logic [CodeW-1:0]  code_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [TimeW-1:0]  now_q;

  logic [TRACK_SLOTS-1:0] slot_act_q;
  logic [CodeW-1:0]  slot_code_q [TRACK_SLOTS];
  logic [RowW-1:0]   slot_row_q  [TRACK_SLOTS];
  logic [ColW-1:0]   slot_col_q  [TRACK_SLOTS];
  logic [TimeW-1:0]  slot_time_q [TRACK_SLOTS];

  logic [ProdW-1:0]  p_q;
  logic [QuotW-1:0]  q0_q;
  logic [TimeW-1:0]  iv_q, iv_d;

  logic              pend_valid_q;
  logic [CodeW-1:0]  pend_code_q;
  logic [RowW-1:0]   pend_row_q;
  logic [ColW-1:0]   pend_col_q;
  logic              pend_held_q;

  logic              out_valid_q;
  logic [CodeW-1:0]  out_code_q;
  logic [RowW-1:0]   out_row_q;
  logic [ColW-1:0]   out_col_q;
  logic              out_held_q;
  logic              out_last_q, out_last_d;

  logic              acc;
  logic              excluded;
  logic              in_in_mx;
  logic [CellW-1:0]  in_cell;
  logic [SlotW-1:0]  idx;
  logic              cur_act;
  logic [RowW-1:0]   cur_row;
  logic [ColW-1:0]   cur_col;
  logic [TimeW-1:0]  cur_time;
  logic              cur_in_mx;
  logic [CellW-1:0]  cur_cell;
  logic              walk_end;
  logic              out_free;
  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  span;
  logic [ProdW-1:0]  rem;
  logic [QuotW-1:0]  quot;
  logic              bypass;

  logic              mem_we, mem_re;
  logic [CellW-1:0]  mem_waddr;
  logic [DepthW:0]   mem_wdata, mem_rdata;
  logic [DepthW-1:0] rd_depth;
  logic              rd_held;
  mul_req_t          mul_req;
  logic [MulW-1:0]   prod;

  logic slot_fill, slot_free, slot_stamp, pend_ld, pend_clr, out_ld, iv_ld, ld_p, ld_q0;

  assign acc       = in_valid_i && (state_q == StIdle);
  assign excluded  = (key_code_i >= excl_lo_q) && (key_code_i <= excl_hi_q);
  assign in_in_mx  = (int'(key_row_i) < MATRIX_ROWS) && (int'(key_col_i) < MATRIX_COLS);
  assign in_cell   = CellW'(int'(key_row_i) * MATRIX_COLS + int'(key_col_i));

  assign idx       = idx_q[SlotW-1:0];
  assign cur_act   = slot_act_q[idx];
  assign cur_row   = slot_row_q[idx];
  assign cur_col   = slot_col_q[idx];
  assign cur_time  = slot_time_q[idx];
  assign cur_in_mx = (int'(cur_row) < MATRIX_ROWS) && (int'(cur_col) < MATRIX_COLS);
  assign cur_cell  = CellW'(int'(cur_row) * MATRIX_COLS + int'(cur_col));

  assign walk_end  = (idx_q == SlotEnd) || (nres_q == OutCntW'(MaxOut));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign elapsed   = now_q - cur_time;
  assign span      = max_q - min_q;
  assign rd_depth  = mem_rdata[DepthW-1:0];
  assign rd_held   = mem_rdata[DepthW];
  assign bypass    = (rd_depth >= FullDepth) || (min_q >= max_q);
  assign rem       = p_q - prod[ProdW-1:0];
  assign quot      = q0_q + QuotW'(rem >= ProdW'(DivisorK));

  assign mem_we    = (state_q == StClear) || (acc && (action_i == ActSample) && in_in_mx);
  assign mem_waddr = (state_q == StClear) ? clr_idx_q : in_cell;
  assign mem_wdata = (state_q == StClear) ? '0 : {held_now_i, depth_value_i};

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    nres_d     = nres_q;
    mem_re     = 1'b0;
    mul_req    = '{en: 1'b0, op: MulScale, a: '0, depth: '0};
    slot_fill  = 1'b0;
    slot_free  = 1'b0;
    slot_stamp = 1'b0;
    pend_ld    = 1'b0;
    pend_clr   = 1'b0;
    out_ld     = 1'b0;
    out_last_d = 1'b0;
    iv_ld      = 1'b0;
    iv_d       = min_q;
    ld_p       = 1'b0;
    ld_q0      = 1'b0;
    case (state_q)
      StClear: begin
        if (clr_idx_q == CellLast) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (acc) begin
          idx_d  = '0;
          nres_d = '0;
          case (action_i)
            ActPress, ActRelease: begin
              if (!excluded) begin
                state_d = StWalk;
              end
            end
            ActTick: begin
              if (rep_en_q) begin
                state_d = StWalk;
              end
            end
            default: ;
          endcase
        end
      end
      StWalk: begin
        case (act_q)
          ActPress: begin
            if (walk_end) begin
              state_d = StIdle;
            end else if (!cur_act) begin
              slot_fill = 1'b1;
              state_d   = StIdle;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          ActRelease: begin
            if (walk_end) begin
              state_d = StIdle;
            end else if (cur_act && (cur_row == row_q) && (cur_col == col_q)) begin
              slot_free = 1'b1;
              state_d   = StIdle;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          ActTick: begin
            if (walk_end) begin
              state_d = StFlush;
            end else if (cur_act && cur_in_mx) begin
              mem_re  = 1'b1;
              state_d = StMemRd;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: state_d = StIdle;
        endcase
      end
      StMemRd: begin
        if (bypass) begin
          iv_ld   = 1'b1;
          iv_d    = min_q;
          state_d = StCmp;
        end else begin
          mul_req = '{en: 1'b1, op: MulScale, a: ProdW'(span), depth: rd_depth};
          state_d = StMulP;
        end
      end
      StMulP: begin
        ld_p    = 1'b1;
        mul_req = '{en: 1'b1, op: MulRecip, a: prod[ProdW-1:0], depth: '0};
        state_d = StMulQ;
      end
      StMulQ: begin
        ld_q0   = 1'b1;
        mul_req = '{en: 1'b1, op: MulBack, a: ProdW'(prod[MulW-1:RecipShift]), depth: '0};
        state_d = StMulR;
      end
      StMulR: begin
        iv_ld   = 1'b1;
        iv_d    = max_q - quot[TimeW-1:0];
        state_d = StCmp;
      end
      StCmp: begin
        if (elapsed < iv_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = StWalk;
        end else if (!pend_valid_q || out_free) begin
          out_ld     = pend_valid_q;
          pend_ld    = 1'b1;
          slot_stamp = 1'b1;
          nres_d     = nres_q + 1'b1;
          idx_d      = idx_q + 1'b1;
          state_d    = StWalk;
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_ld     = 1'b1;
          out_last_d = 1'b1;
          pend_clr   = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      idx_q        <= '0;
      nres_q       <= '0;
      clr_idx_q    <= '0;
      slot_act_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nres_q  <= nres_d;
      if (state_q == StClear) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (slot_fill) begin
        slot_act_q[idx] <= 1'b1;
      end else if (slot_free) begin
        slot_act_q[idx] <= 1'b0;
      end
      if (pend_ld) begin
        pend_valid_q <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_en_q  <= 1'b1;
      min_q     <= 16'd20;
      max_q     <= 16'd200;
      excl_lo_q <= 16'hFFFF;
      excl_hi_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRepeatEn: rep_en_q  <= cfg_wdata_i[0];
        CfgMinIv:    min_q     <= cfg_wdata_i;
        CfgMaxIv:    max_q     <= cfg_wdata_i;
        CfgExclLo:   excl_lo_q <= cfg_wdata_i;
        CfgExclHi:   excl_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_q  <= action_i;
      code_q <= key_code_i;
      row_q  <= key_row_i;
      col_q  <= key_col_i;
      now_q  <= now_time_i;
    end
    if (slot_fill) begin
      slot_code_q[idx] <= code_q;
      slot_row_q[idx]  <= row_q;
      slot_col_q[idx]  <= col_q;
    end
    if (slot_fill || slot_stamp) begin
      slot_time_q[idx] <= now_q;
    end
    if (ld_p) begin
      p_q <= prod[ProdW-1:0];
    end
    if (ld_q0) begin
      q0_q <= prod[MulW-1:RecipShift];
    end
    if (iv_ld) begin
      iv_q <= iv_d;
    end
    if (out_ld) begin
      out_code_q <= pend_code_q;
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_held_q <= pend_held_q;
      out_last_q <= out_last_d;
    end
    if (pend_ld) begin
      pend_code_q <= slot_code_q[idx];
      pend_row_q  <= cur_row;
      pend_col_q  <= cur_col;
      pend_held_q <= rd_held;
    end
  end

  dsk_cell_mem #(
    .Cells (Cells)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cur_cell),
    .rdata_o (mem_rdata)
  );

  dsk_mul_unit u_mul_unit (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign out_keycode_o = out_code_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign reregister_o  = out_held_q;
  assign last_in_run_o = out_last_q;

endmodule

FILE: rtl/core/dsk_checker.sv
`include "assert_macros.svh"

module dsk_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [dsk_pkg::ActW-1:0]      action_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [dsk_pkg::CodeW-1:0]     out_keycode_o,
  input logic [dsk_pkg::RowW-1:0]      out_row_o,
  input logic [dsk_pkg::ColW-1:0]      out_col_o,
  input logic                          reregister_o,
  input logic                          last_in_run_o
);
  import dsk_pkg::*;

  logic [CodeW+RowW+ColW+1:0] out_pay;

  assign out_pay = {out_keycode_o, out_row_o, out_col_o, reregister_o, last_in_run_o};

  // A stalled result keeps its valid and its payload.
  `DSK_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_pay))

  // A depth sample for a cell of the matrix is stored in the transfer cycle and leaves the block ready.
  `DSK_ASSERT_NEXT(a_sample_ready, in_valid_i && !in_stall_o && action_i == ActSample, !in_stall_o)

  // While a result that is not the last of its tick is offered, the tick is still running.
  `DSK_ASSERT_NOW(a_run_busy, out_valid_o && !last_in_run_o, in_stall_o)

endmodule

bind depth_scaled_key_repeat_scheduler dsk_checker u_dsk_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dsk_pkg::*;

  localparam int Slots        = TrackSlotsDef;
  localparam int Cols         = MatrixColsDef;
  localparam int Cells        = MatrixRowsDef * MatrixColsDef;
  localparam int ClearCycles  = Cells + 16;
  localparam int SettleCycles = 6 * Slots + 16;
  localparam int HoldCycles   = 300;
  localparam int PhaseItems   = 100;
  localparam longint LimitNs  = 20_000_000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;
  localparam int unsigned DepthScale = 1000;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             rereg;
    logic             last;
  } repeat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ActW-1:0]     action_i;
  logic [CodeW-1:0]    key_code_i;
  logic [RowW-1:0]     key_row_i;
  logic [ColW-1:0]     key_col_i;
  logic [DepthW-1:0]   depth_value_i;
  logic                held_now_i;
  logic [TimeW-1:0]    now_time_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CodeW-1:0]    out_keycode_o;
  logic [RowW-1:0]     out_row_o;
  logic [ColW-1:0]     out_col_o;
  logic                reregister_o;
  logic                last_in_run_o;

  depth_scaled_key_repeat_scheduler dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic              rep_en;
  logic [TimeW-1:0]  iv_min;
  logic [TimeW-1:0]  iv_max;
  logic [CodeW-1:0]  excl_lo;
  logic [CodeW-1:0]  excl_hi;
  logic              slot_busy  [Slots];
  logic [CodeW-1:0]  slot_code  [Slots];
  logic [RowW-1:0]   slot_row   [Slots];
  logic [ColW-1:0]   slot_col   [Slots];
  logic [TimeW-1:0]  slot_stamp [Slots];
  logic [DepthW-1:0] depth_mem  [Cells];
  logic              held_mem   [Cells];
  repeat_t           due_repeats[$];

  int               fail_count    = 0;
  int               send_idle_pct = 21;
  int               recv_idle_pct = 54;
  int               hold_seq      = 0;
  logic [TimeW-1:0] clock_now     = '0;

  function automatic logic [TimeW-1:0] repeat_interval(logic [DepthW-1:0] d);
    int unsigned span;
    int unsigned iv;
    if (d >= FullDepth || iv_min >= iv_max) return iv_min;
    span = (32'(iv_max) - 32'(iv_min)) * 32'(d);
    iv = 32'(iv_max) - span / DepthScale;
    if (iv < 32'(iv_min)) return iv_min;
    if (iv > 32'(iv_max)) return iv_max;
    return 16'(iv);
  endfunction

  task automatic predict_item();
    int               cell_idx;
    logic [TimeW-1:0] elapsed;
    repeat_t          rep;
    repeat_t          burst[$];
    case (action_i)
      ActPress, ActRelease: begin
        if (!(key_code_i >= excl_lo && key_code_i <= excl_hi)) begin
          for (int i = 0; i < Slots; i++) begin
            if (action_i == ActPress && !slot_busy[i]) begin
              slot_busy[i]  = 1'b1;
              slot_code[i]  = key_code_i;
              slot_row[i]   = key_row_i;
              slot_col[i]   = key_col_i;
              slot_stamp[i] = now_time_i;
              break;
            end
            if (action_i == ActRelease && slot_busy[i] &&
                slot_row[i] == key_row_i && slot_col[i] == key_col_i) begin
              slot_busy[i] = 1'b0;
              break;
            end
          end
        end
      end
      ActSample: begin
        cell_idx = key_row_i * Cols + key_col_i;
        depth_mem[cell_idx] = depth_value_i;
        held_mem[cell_idx]  = held_now_i;
      end
      default: begin
        if (rep_en) begin
          for (int i = 0; i < Slots && burst.size() < MaxOut; i++) begin
            cell_idx = slot_row[i] * Cols + slot_col[i];
            elapsed = now_time_i - slot_stamp[i];
            if (slot_busy[i] && elapsed >= repeat_interval(depth_mem[cell_idx])) begin
              slot_stamp[i] = now_time_i;
              rep.code  = slot_code[i];
              rep.row   = slot_row[i];
              rep.col   = slot_col[i];
              rep.rereg = held_mem[cell_idx];
              rep.last  = 1'b0;
              burst.push_back(rep);
            end
          end
          if (burst.size() > 0) begin
            rep = burst.pop_back();
            rep.last = 1'b1;
            burst.push_back(rep);
          end
          foreach (burst[j]) due_repeats.push_back(burst[j]);
        end
      end
    endcase
  endtask

  initial begin : repeat_predictor
    rep_en  = 1'b1;
    iv_min  = 16'd20;
    iv_max  = 16'd200;
    excl_lo = 16'hFFFF;
    excl_hi = 16'h0000;
    for (int i = 0; i < Slots; i++) begin
      slot_busy[i]  = 1'b0;
      slot_code[i]  = '0;
      slot_row[i]   = '0;
      slot_col[i]   = '0;
      slot_stamp[i] = '0;
    end
    for (int k = 0; k < Cells; k++) begin
      depth_mem[k] = '0;
      held_mem[k]  = 1'b0;
    end
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (cfg_we_i) begin
          case (cfg_idx_i)
            CfgRepeatEn: rep_en  = cfg_wdata_i[0];
            CfgMinIv:    iv_min  = cfg_wdata_i;
            CfgMaxIv:    iv_max  = cfg_wdata_i;
            CfgExclLo:   excl_lo = cfg_wdata_i;
            CfgExclHi:   excl_hi = cfg_wdata_i;
            default: ;
          endcase
        end
        if (in_valid_i && !in_stall_o) predict_item();
      end
    end
  end

  task automatic check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  initial begin : repeat_checker
    repeat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (due_repeats.size() == 0) begin
          $display("%0t: repeat transfer expected none, got code 0x%0h row %0d col %0d",
                   $time, out_keycode_o, out_row_o, out_col_o);
          fail_count++;
        end else begin
          want = due_repeats.pop_front();
          check_field("out_keycode", want.code, out_keycode_o);
          check_field("out_row", want.row, out_row_o);
          check_field("out_col", want.col, out_col_o);
          check_field("reregister", want.rereg, reregister_o);
          check_field("last_in_run", want.last, last_in_run_o);
        end
      end
    end
  end

  initial begin : result_stall
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(action_e act, logic [CodeW-1:0] code, logic [RowW-1:0] row,
                           logic [ColW-1:0] col, logic [DepthW-1:0] depth, logic held,
                           logic [TimeW-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    key_code_i    <= code;
    key_row_i     <= row;
    key_col_i     <= col;
    depth_value_i <= depth;
    held_now_i    <= held;
    now_time_i    <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (due_repeats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic en, logic [TimeW-1:0] lo_iv, logic [TimeW-1:0] hi_iv,
                           logic [CodeW-1:0] lo_code, logic [CodeW-1:0] hi_code);
    write_reg(CfgRepeatEn, {15'($urandom), en});
    write_reg(CfgMinIv, lo_iv);
    write_reg(CfgMaxIv, hi_iv);
    write_reg(CfgExclLo, lo_code);
    write_reg(CfgExclHi, hi_code);
  endtask

  task automatic test_reset_defaults();
    send_item(ActPress, 16'h0000, 3'd0, 4'd0, '0, 1'b0, 16'd0);
    send_item(ActPress, 16'hFFFF, 3'd7, 4'd15, '1, 1'b1, 16'd0);
    send_item(ActSample, '0, 3'd7, 4'd15, FullDepth, 1'b1, '1);
    send_item(ActSample, '1, 3'd0, 4'd0, '0, 1'b0, '0);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, 16'd19);
    send_item(ActTick, '1, '1, '1, '1, 1'b1, 16'd20);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, 16'd200);
    send_item(ActRelease, 16'h0005, 3'd3, 4'd3, '0, 1'b0, '0);
    send_item(ActRelease, 16'h0001, 3'd0, 4'd0, '0, 1'b0, '0);
    send_item(ActSample, '0, 3'd7, 4'd15, 10'd1023, 1'b0, '0);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, 16'h0010);
    send_item(ActRelease, 16'hFFFF, 3'd7, 4'd15, '0, 1'b0, '0);
  endtask

  task automatic test_full_table();
    clock_now = 16'h4000;
    for (int i = 0; i <= Slots; i++)
      send_item(ActPress, 16'h0100 + 16'(i), 3'(i), 4'(15 - i), '0, 1'b0, clock_now);
    send_item(ActSample, '0, 3'd2, 4'd13, 10'd500, 1'b1, '0);
    clock_now += 16'd110;
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
    clock_now += 16'd90;
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
  endtask

  task automatic test_config_extremes();
    drain_block();
    write_reg(CfgRepeatEn, 16'hFFFE);
    clock_now += 16'd1000;
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
    drain_block();
    write_reg(CfgSpare, 16'hFFFF);
    write_all(1'b1, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
    clock_now += 16'd1;
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
    drain_block();
    write_reg(CfgMinIv, 16'hFFFF);
    write_reg(CfgMaxIv, 16'h0000);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now + 16'hFFFE);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now + 16'hFFFF);
    clock_now += 16'hFFFF;
    drain_block();
    write_reg(CfgMinIv, 16'h0000);
    write_reg(CfgMaxIv, 16'hFFFF);
    send_item(ActSample, '0, 3'd2, 4'd13, 10'd999, 1'b0, '0);
    clock_now += 16'd66;
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
    drain_block();
    write_reg(CfgExclLo, 16'h0000);
    write_reg(CfgExclHi, 16'hFFFF);
    send_item(ActRelease, 16'h0100, 3'd0, 4'd15, '0, 1'b0, '0);
    send_item(ActPress, 16'h0300, 3'd5, 4'd5, '0, 1'b0, clock_now);
    drain_block();
    write_all(1'b1, 16'd0, 16'd0, 16'h0101, 16'h0101);
    send_item(ActRelease, 16'h0101, 3'd1, 4'd14, '0, 1'b0, '0);
    send_item(ActRelease, 16'h0100, 3'd0, 4'd15, '0, 1'b0, '0);
    send_item(ActPress, 16'h0101, 3'd6, 4'd6, '0, 1'b0, clock_now);
    send_item(ActTick, '0, '0, '0, '0, 1'b0, clock_now);
  endtask

  task automatic test_pressure();
    drain_block();
    write_reg(CfgExclLo, 16'hFFFF);
    write_reg(CfgExclHi, 16'h0000);
    send_item(ActPress, 16'h0200, 3'd0, 4'd15, '0, 1'b0, clock_now);
    hold_seq++;
    repeat (6) begin
      clock_now += 16'd1;
      send_item(ActTick, 16'($urandom), 3'($urandom), 4'($urandom), 10'($urandom),
                1'($urandom), clock_now);
    end
    drain_block();
    for (int i = 0; i < Slots; i++)
      send_item(ActRelease, 16'h0100 + 16'(i), 3'(i), 4'(15 - i), '0, 1'b0, '0);
  endtask

  task automatic run_random(int count);
    int                sel;
    int                pick;
    logic [CodeW-1:0]  code;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [DepthW-1:0] depth;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, Slots - 1);
      code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      row  = 3'($urandom);
      col  = 4'($urandom);
      if ($urandom_range(0, 3) != 0 && slot_busy[pick]) begin
        row = slot_row[pick];
        col = slot_col[pick];
      end
      case ($urandom_range(0, 4))
        0:       depth = '0;
        1:       depth = FullDepth;
        2:       depth = 10'($urandom_range(1000, 1023));
        default: depth = 10'($urandom_range(0, 999));
      endcase
      if (sel < 12) begin
        send_item(action_e'(2'($urandom)), 16'($urandom), 3'($urandom), 4'($urandom),
                  10'($urandom), 1'($urandom), 16'($urandom));
      end else if (sel < 37) begin
        send_item(ActPress, code, 3'($urandom), 4'($urandom), 10'($urandom),
                  1'($urandom), clock_now);
      end else if (sel < 52) begin
        send_item(ActRelease, code, row, col, 10'($urandom), 1'($urandom), 16'($urandom));
      end else if (sel < 70) begin
        send_item(ActSample, 16'($urandom), row, col, depth, 1'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 19) == 0) clock_now += 16'($urandom);
        else clock_now += 16'($urandom_range(0, 90));
        send_item(ActTick, 16'($urandom), 3'($urandom), 4'($urandom), 10'($urandom),
                  1'($urandom), clock_now);
      end
    end
  endtask

  task automatic test_random_phase(int idle_send, int idle_recv, logic [TimeW-1:0] lo_iv,
                                   logic [TimeW-1:0] hi_iv, logic [CodeW-1:0] lo_code,
                                   logic [CodeW-1:0] hi_code);
    drain_block();
    send_idle_pct = idle_send;
    recv_idle_pct = idle_recv;
    write_all(1'b1, lo_iv, hi_iv, lo_code, hi_code);
    run_random(PhaseItems);
  endtask

  initial begin : run_limit
    #(LimitNs);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = ActPress;
    key_code_i    = '0;
    key_row_i     = '0;
    key_col_i     = '0;
    depth_value_i = '0;
    held_now_i    = 1'b0;
    now_time_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (ClearCycles) @(posedge clk_i);
    test_reset_defaults();
    test_full_table();
    test_config_extremes();
    test_pressure();
    test_random_phase(21, 54, 16'd20, 16'd200, 16'd10, 16'd20);
    test_random_phase(54, 21, 16'd5, 16'd60, 16'd0, 16'd3);
    test_random_phase(0, 0, 16'd0, 16'd1000, 16'hFFFF, 16'h0000);
    drain_block();
    if (fail_count == 0 && due_repeats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
